// ----- sv/rpy_to_unit_quaternion_defines.svh -----
// Assertion macros shared by the checker of the quaternion block
`ifndef RPY_TO_UNIT_QUATERNION_DEFINES_SVH
`define RPY_TO_UNIT_QUATERNION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RPYQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RPYQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rpyq_pkg.sv -----
// Types, constants and tables for the roll/pitch/yaw to quaternion block
package rpyq_pkg;

	localparam int ANGLE_BITS_DEF  = 16;
	localparam int QUAT_BITS_DEF   = 16;
	localparam int CORDIC_STEPS    = 30;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	// Q30 fraction bits of the trig and product path
	localparam int FRAC = 30;
	// datapath word for sin/cos, products and quaternion terms
	localparam int CW   = 34;
	// sum of squares word and root word
	localparam int N2W  = 64;
	localparam int RW   = 32;

	typedef logic signed [CW-1:0] cord_t;

	// arctangent of 2^-i in 32-bit phase units (full circle = 2^32)
	function automatic logic [31:0] atan_phase(input int idx);
		logic [31:0] v;
		unique case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335086;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41721;
			15: v = 32'd20860;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2607;
			19: v = 32'd1303;
			20: v = 32'd651;
			21: v = 32'd325;
			22: v = 32'd162;
			23: v = 32'd81;
			24: v = 32'd40;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd2;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// Q30 product with floor
	function automatic cord_t mul_q30(input cord_t a, input cord_t b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return cord_t'(p[FRAC+CW-1:FRAC]);
	endfunction

endpackage

// ----- sv/rpyq_if.sv -----
// Stream interfaces: angle triple in, quaternion out
interface rpyq_in_if import rpyq_pkg::*; #(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();
	logic valid;
	logic ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
		input ready);
	modport sink (input valid, input roll_angle, input pitch_angle, input yaw_angle,
		output ready);
endinterface

interface rpyq_out_if import rpyq_pkg::*; #(parameter int QUAT_BITS = QUAT_BITS_DEF) ();
	logic valid;
	logic ready;
	logic signed [QUAT_BITS-1:0] quat_x;
	logic signed [QUAT_BITS-1:0] quat_y;
	logic signed [QUAT_BITS-1:0] quat_z;
	logic signed [QUAT_BITS-1:0] quat_w;
	modport source (output valid, output quat_x, output quat_y, output quat_z, output quat_w,
		input ready);
	modport sink (input valid, input quat_x, input quat_y, input quat_z, input quat_w,
		output ready);
endinterface

// ----- sv/rpyq_cordic.sv -----
// Three-lane pipelined rotation CORDIC: half-angle sine and cosine in Q30
module rpyq_cordic import rpyq_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_i,
	input  logic signed [ANGLE_BITS-1:0] ang_i [3],
	output logic                         vld_o,
	output cord_t                        sin_o [3],
	output cord_t                        cos_o [3]
);

	logic [CORDIC_STEPS:0] vld_s;
	cord_t x_s [CORDIC_STEPS+1][3];
	cord_t y_s [CORDIC_STEPS+1][3];
	cord_t z_s [CORDIC_STEPS+1][3];
	cord_t phase [3];

	// angle code to half-angle phase on a 2^32 circle
	for (genvar l = 0; l < 3; l++) begin : g_phase
		if (ANGLE_BITS <= 31) begin : g_exact
			assign phase[l] = CW'(ang_i[l]) <<< (31 - ANGLE_BITS);
		end else begin : g_floor
			assign phase[l] = CW'(ang_i[l] >>> 1);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_STEPS-1:0], vld_i};
		end
	end

	// start vector: gain-compensated unit x, residual phase z
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= CW'(CORDIC_GAIN_Q30);
				y_s[0][l] <= '0;
				z_s[0][l] <= phase[l];
			end
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		for (genvar l = 0; l < 3; l++) begin : g_lane
			cord_t dx, dy, at;
			assign dx = y_s[i][l] >>> i;
			assign dy = x_s[i][l] >>> i;
			assign at = CW'(atan_phase(i));
			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_s[i][l][CW-1]) begin
						x_s[i+1][l] <= x_s[i][l] - dx;
						y_s[i+1][l] <= y_s[i][l] + dy;
						z_s[i+1][l] <= z_s[i][l] - at;
					end else begin
						x_s[i+1][l] <= x_s[i][l] + dx;
						y_s[i+1][l] <= y_s[i][l] - dy;
						z_s[i+1][l] <= z_s[i][l] + at;
					end
				end
			end
		end
	end

	// last stage drives the outputs
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign sin_o[l] = y_s[CORDIC_STEPS][l];
		assign cos_o[l] = x_s[CORDIC_STEPS][l];
	end

	assign vld_o = vld_s[CORDIC_STEPS];

endmodule

// ----- sv/rpyq_qmul.sv -----
// Quaternion products and sum of squares, five register stages
module rpyq_qmul import rpyq_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  cord_t          sin_i [3],
	input  cord_t          cos_i [3],
	output logic           vld_o,
	output cord_t          q_o [4],
	output logic [N2W-1:0] n2_o
);

	logic [4:0] vld_s;
	cord_t p_s1 [4];
	cord_t sy_s1, cy_s1;
	cord_t t_s2 [8];
	cord_t q_s3 [4];
	cord_t q_s4 [4];
	logic [N2W-1:0] sq_s4 [4];
	cord_t q_s5 [4];
	logic [N2W-1:0] n2_s5;
	logic [N2W-1:0] sq [4];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], vld_i};
		end
	end

	// squares keep the low 64 bits
	for (genvar k = 0; k < 4; k++) begin : g_sq
		logic signed [2*CW-1:0] full;
		assign full  = q_s3[k] * q_s3[k];
		assign sq[k] = full[N2W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// roll/pitch pair products
			p_s1[0] <= mul_q30(sin_i[0], cos_i[1]);
			p_s1[1] <= mul_q30(cos_i[0], sin_i[1]);
			p_s1[2] <= mul_q30(cos_i[0], cos_i[1]);
			p_s1[3] <= mul_q30(sin_i[0], sin_i[1]);
			sy_s1   <= sin_i[2];
			cy_s1   <= cos_i[2];
			// times yaw terms
			t_s2[0] <= mul_q30(p_s1[0], cy_s1);
			t_s2[1] <= mul_q30(p_s1[1], sy_s1);
			t_s2[2] <= mul_q30(p_s1[1], cy_s1);
			t_s2[3] <= mul_q30(p_s1[0], sy_s1);
			t_s2[4] <= mul_q30(p_s1[2], sy_s1);
			t_s2[5] <= mul_q30(p_s1[3], cy_s1);
			t_s2[6] <= mul_q30(p_s1[2], cy_s1);
			t_s2[7] <= mul_q30(p_s1[3], sy_s1);
			// x, y, z, w
			q_s3[0] <= t_s2[0] - t_s2[1];
			q_s3[1] <= t_s2[2] + t_s2[3];
			q_s3[2] <= t_s2[4] - t_s2[5];
			q_s3[3] <= t_s2[6] + t_s2[7];
			// squares, then their sum
			q_s4  <= q_s3;
			sq_s4 <= sq;
			q_s5  <= q_s4;
			n2_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3];
		end
	end

	assign vld_o = vld_s[4];
	assign q_o   = q_s5;
	assign n2_o  = n2_s5;

endmodule

// ----- sv/rpyq_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband
module rpyq_isqrt import rpyq_pkg::*; #(
	parameter int SW = 4*CW
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [N2W-1:0] val_i,
	input  logic [SW-1:0]  side_i,
	output logic           vld_o,
	output logic [RW-1:0]  root_o,
	output logic [SW-1:0]  side_o
);

	logic [RW:0] vld_s;
	logic [N2W-1:0] rem_s  [RW+1];
	logic [N2W-1:0] root_s [RW+1];
	logic [SW-1:0]  side_s [RW+1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-1:0], vld_i};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= val_i;
			root_s[0] <= '0;
			side_s[0] <= side_i;
		end
	end

	// restoring digit step
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [N2W-1:0] bitv, trial;
		assign bitv  = N2W'(1) << (N2W - 2 - 2*k);
		assign trial = root_s[k] + bitv;
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial;
					root_s[k+1] <= (root_s[k] >> 1) + bitv;
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign vld_o  = vld_s[RW];
	assign root_o = root_s[RW][RW-1:0];
	assign side_o = side_s[RW];

endmodule

// ----- sv/rpyq_div.sv -----
// Four-lane pipelined divide by the norm, rounding and saturation
module rpyq_div import rpyq_pkg::*; #(
	parameter int QUAT_BITS = QUAT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  logic [RW-1:0]        den_i,
	input  cord_t                q_i [4],
	output logic                 vld_o,
	output logic [QUAT_BITS-1:0] quat_o [4]
);

	localparam int DW = CW + QUAT_BITS;
	localparam logic [QUAT_BITS-1:0] QMAX = {1'b0, {(QUAT_BITS-1){1'b1}}};

	logic [QUAT_BITS+1:0] vld_s;
	logic [RW-1:0]        den_s  [QUAT_BITS+1];
	logic                 zero_s [QUAT_BITS+1];
	logic                 neg_s  [QUAT_BITS+1][4];
	logic [DW-1:0]        rem_s  [QUAT_BITS+1][4];
	logic [QUAT_BITS-1:0] quo_s  [QUAT_BITS+1][4];
	logic [QUAT_BITS-1:0] out_s  [4];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QUAT_BITS:0], vld_i};
		end
	end

	// numerator: |q| * 2^(QUAT_BITS-1) plus half the divisor
	for (genvar k = 0; k < 4; k++) begin : g_prep
		logic [CW-1:0] mag;
		logic [DW-1:0] num;
		assign mag = q_i[k][CW-1] ? CW'(-q_i[k]) : CW'(q_i[k]);
		assign num = (DW'(mag) << (QUAT_BITS - 1)) + DW'(den_i >> 1);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[0][k] <= q_i[k][CW-1];
				rem_s[0][k] <= num;
				quo_s[0][k] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= den_i;
			zero_s[0] <= (den_i == '0);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QUAT_BITS; j++) begin : g_step
		localparam int SH = QUAT_BITS - 1 - j;
		logic [DW-1:0] dsh;
		assign dsh = DW'(den_s[j]) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1]  <= den_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
		for (genvar k = 0; k < 4; k++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					neg_s[j+1][k] <= neg_s[j][k];
					if (rem_s[j][k] >= dsh) begin
						rem_s[j+1][k] <= rem_s[j][k] - dsh;
						quo_s[j+1][k] <= quo_s[j][k] | (QUAT_BITS'(1) << SH);
					end else begin
						rem_s[j+1][k] <= rem_s[j][k];
						quo_s[j+1][k] <= quo_s[j][k];
					end
				end
			end
		end
	end

	// saturate, restore sign; zero norm gives the identity
	for (genvar k = 0; k < 4; k++) begin : g_out
		logic [QUAT_BITS-1:0] sat;
		assign sat = (quo_s[QUAT_BITS][k] > QMAX) ? QMAX : quo_s[QUAT_BITS][k];
		always_ff @(posedge clk) begin
			if (en) begin
				if (zero_s[QUAT_BITS]) begin
					out_s[k] <= (k == 3) ? QMAX : '0;
				end else begin
					out_s[k] <= neg_s[QUAT_BITS][k] ? (QUAT_BITS'(0) - sat) : sat;
				end
			end
		end
		assign quat_o[k] = out_s[k];
	end

	assign vld_o = vld_s[QUAT_BITS+1];

endmodule

// ----- sv/rpy_to_unit_quaternion.sv -----
// Throughput: one triple per cycle unless the output stalls; 30 CORDIC stages, 5 product
// stages, 32 root stages and QUAT_BITS divide stages plus prep and output registers, one
// global enable.
// A stalled output freezes the whole pipeline; ready follows output space.
// Reset (arst_n low, asynchronous) clears every stage valid bit; data is not reset.
module rpy_to_unit_quaternion import rpyq_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int QUAT_BITS  = QUAT_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rpyq_in_if.sink   angles,
	rpyq_out_if.source quat
);

	logic en;
	logic signed [ANGLE_BITS-1:0] ang [3];
	logic vld_trig, vld_prod, vld_root, vld_out;
	cord_t sin_v [3];
	cord_t cos_v [3];
	cord_t q_v [4];
	cord_t q_d [4];
	logic [N2W-1:0] n2;
	logic [RW-1:0] root;
	logic [4*CW-1:0] side_in, side_out;
	logic [QUAT_BITS-1:0] quat_v [4];

	// pipeline advances unless a finished result is held
	assign en           = !quat.valid || quat.ready;
	assign angles.ready = en;

	assign ang[0] = angles.roll_angle;
	assign ang[1] = angles.pitch_angle;
	assign ang[2] = angles.yaw_angle;

	rpyq_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(angles.valid), .ang_i(ang),
		.vld_o(vld_trig), .sin_o(sin_v), .cos_o(cos_v)
	);

	rpyq_qmul u_qmul (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_trig), .sin_i(sin_v),
		.cos_i(cos_v), .vld_o(vld_prod), .q_o(q_v), .n2_o(n2)
	);

	// quaternion terms ride alongside the root
	assign side_in = {q_v[3], q_v[2], q_v[1], q_v[0]};

	rpyq_isqrt #(.SW(4*CW)) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_prod), .val_i(n2),
		.side_i(side_in), .vld_o(vld_root), .root_o(root), .side_o(side_out)
	);

	for (genvar k = 0; k < 4; k++) begin : g_unpack
		assign q_d[k] = cord_t'(side_out[k*CW +: CW]);
	end

	rpyq_div #(.QUAT_BITS(QUAT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_root), .den_i(root),
		.q_i(q_d), .vld_o(vld_out), .quat_o(quat_v)
	);

	assign quat.valid  = vld_out;
	assign quat.quat_x = quat_v[0];
	assign quat.quat_y = quat_v[1];
	assign quat.quat_z = quat_v[2];
	assign quat.quat_w = quat_v[3];

endmodule

// ----- sv/rpyq_checker.sv -----
// Port-level checker for the quaternion block and its bind
`include "rpy_to_unit_quaternion_defines.svh"

module rpyq_checker import rpyq_pkg::*; #(
	parameter int QUAT_BITS = QUAT_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [QUAT_BITS-1:0] quat_x,
	input logic [QUAT_BITS-1:0] quat_y,
	input logic [QUAT_BITS-1:0] quat_z,
	input logic [QUAT_BITS-1:0] quat_w
);

	localparam logic [QUAT_BITS-1:0] MOST_NEG = {1'b1, {(QUAT_BITS-1){1'b0}}};

	// held result stays valid
	`RPYQ_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped in stall")
	// held result keeps its value
	`RPYQ_ASSERT_NXT(a_hold_data, out_valid && !out_ready,
		$stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(quat_w),
		"result changed in stall")
	// input side never blocks while the output drains
	`RPYQ_ASSERT_NOW(a_ready_flow, out_ready || !out_valid, in_ready, "input stalled needlessly")
	// saturation keeps every component off the most negative code
	`RPYQ_ASSERT_NOW(a_sat, out_valid,
		quat_x != MOST_NEG && quat_y != MOST_NEG && quat_z != MOST_NEG && quat_w != MOST_NEG,
		"component not saturated")

endmodule

bind rpy_to_unit_quaternion rpyq_checker #(.QUAT_BITS(QUAT_BITS)) u_rpyq_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(angles.ready), .out_valid(quat.valid),
	.out_ready(quat.ready), .quat_x(quat.quat_x), .quat_y(quat.quat_y),
	.quat_z(quat.quat_z), .quat_w(quat.quat_w)
);

// ----- tb/tb_rpy_to_unit_quaternion.sv -----
// Self-checking testbench for the roll/pitch/yaw to unit quaternion block
module tb_rpy_to_unit_quaternion;
	import rpyq_pkg::*;

	localparam int AB = ANGLE_BITS_DEF;
	localparam int QB = QUAT_BITS_DEF;
	localparam int GAIN = 652032874;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct {
		logic [AB-1:0] roll;
		logic [AB-1:0] pitch;
		logic [AB-1:0] yaw;
	} rpy_t;

	typedef struct {
		logic [QB-1:0] x;
		logic [QB-1:0] y;
		logic [QB-1:0] z;
		logic [QB-1:0] w;
	} quat_t;

	logic clk;
	logic arst_n;

	rpyq_in_if  #(.ANGLE_BITS(AB)) angles_if ();
	rpyq_out_if #(.QUAT_BITS(QB))  quat_if ();

	rpy_to_unit_quaternion #(.ANGLE_BITS(AB), .QUAT_BITS(QB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles_if.sink),
		.quat   (quat_if.source)
	);

	rpy_t   pending_angles[$];
	quat_t  expected_quats[$];
	int     send_idle_pct;
	int     recv_idle_pct;
	int     hold_request;
	int     hold_left;
	int     mismatches;
	int     quats_checked;
	longint cycles;

	// arctangents of 2^-i in 32-bit phase units
	longint atan_tbl[30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
		41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
		10, 5, 2, 1
	};

	// sine and cosine of half the binary angle, Q30
	function automatic void half_sin_cos(input logic [AB-1:0] code, output longint s,
			output longint c);
		longint x, y, z, dx, dy;
		x = GAIN;
		y = 0;
		z = longint'($signed(code)) * (longint'(1) << (31 - AB));
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - atan_tbl[i];
			end else begin
				x = x + dx; y = y - dy; z = z + atan_tbl[i];
			end
		end
		s = y;
		c = x;
	endfunction

	function automatic longint triple_q30(input longint a, input longint b, input longint c);
		return (((a * b) >>> 30) * c) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [QB-1:0] normalize_comp(input longint q, input longint unsigned n);
		longint unsigned mag, r, qmax;
		qmax = (64'd1 << (QB - 1)) - 1;
		mag = (q < 0) ? longint'(-q) : longint'(q);
		r = (mag * (64'd1 << (QB - 1)) + n / 2) / n;
		if (r > qmax) r = qmax;
		return (q < 0) ? QB'(-r) : QB'(r);
	endfunction

	function automatic quat_t predict_quat(input rpy_t a);
		longint sr, cr, sp, cp, sy, cy;
		longint q[4];
		longint unsigned n2, n;
		quat_t res;
		half_sin_cos(a.roll, sr, cr);
		half_sin_cos(a.pitch, sp, cp);
		half_sin_cos(a.yaw, sy, cy);
		q[0] = triple_q30(sr, cp, cy) - triple_q30(cr, sp, sy);
		q[1] = triple_q30(cr, sp, cy) + triple_q30(sr, cp, sy);
		q[2] = triple_q30(cr, cp, sy) - triple_q30(sr, sp, cy);
		q[3] = triple_q30(cr, cp, cy) + triple_q30(sr, sp, sy);
		n2 = 0;
		for (int k = 0; k < 4; k++) n2 = n2 + longint'(q[k] * q[k]);
		n = int_sqrt(n2);
		if (n == 0) begin
			res.x = '0; res.y = '0; res.z = '0;
			res.w = QB'((1 << (QB - 1)) - 1);
		end else begin
			res.x = normalize_comp(q[0], n);
			res.y = normalize_comp(q[1], n);
			res.z = normalize_comp(q[2], n);
			res.w = normalize_comp(q[3], n);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [QB-1:0] got,
			input logic [QB-1:0] want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what,
			$signed(got), $signed(want), quats_checked);
		mismatches++;
	endtask

	task automatic queue_angles(input int r, input int p, input int y);
		rpy_t a;
		a.roll = AB'(r);
		a.pitch = AB'(p);
		a.yaw = AB'(y);
		pending_angles.insert(pending_angles.size(), a);
	endtask

	// random triples: mostly full range, some near zero or near the wrap point
	task automatic queue_random(input int count);
		int pick[3];
		for (int i = 0; i < count; i++) begin
			for (int f = 0; f < 3; f++) begin
				case ($urandom_range(9))
					0: pick[f] = $urandom_range(64) - 32;
					1: pick[f] = 32'h8000 + $urandom_range(64) - 32;
					default: pick[f] = $urandom;
				endcase
			end
			queue_angles(pick[0], pick[1], pick[2]);
		end
	endtask

	task automatic wait_drained();
		while (pending_angles.size() != 0 || angles_if.valid || expected_quats.size() != 0)
			@(posedge clk);
	endtask

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// driver: offers the next pending triple, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		rpy_t a;
		if (!arst_n) begin
			angles_if.valid <= 1'b0;
			angles_if.roll_angle <= '0;
			angles_if.pitch_angle <= '0;
			angles_if.yaw_angle <= '0;
		end else begin
			if (angles_if.valid && angles_if.ready) begin
				a.roll = angles_if.roll_angle;
				a.pitch = angles_if.pitch_angle;
				a.yaw = angles_if.yaw_angle;
				expected_quats.insert(expected_quats.size(), predict_quat(a));
			end
			if (!angles_if.valid || angles_if.ready) begin
				if (pending_angles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					a = pending_angles.pop_front();
					angles_if.roll_angle <= a.roll;
					angles_if.pitch_angle <= a.pitch;
					angles_if.yaw_angle <= a.yaw;
					angles_if.valid <= 1'b1;
				end else begin
					angles_if.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_request > 0 && hold_left == 0) begin
			hold_left <= hold_request;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: checks each quaternion transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		quat_t want;
		if (!arst_n) begin
			quat_if.ready <= 1'b0;
		end else begin
			if (quat_if.valid && quat_if.ready) begin
				if (expected_quats.size() == 0) begin
					report_mismatch("unexpected transfer", quat_if.quat_x, '0);
				end else begin
					want = expected_quats.pop_front();
					if (quat_if.quat_x !== want.x) report_mismatch("quat_x", quat_if.quat_x, want.x);
					if (quat_if.quat_y !== want.y) report_mismatch("quat_y", quat_if.quat_y, want.y);
					if (quat_if.quat_z !== want.z) report_mismatch("quat_z", quat_if.quat_z, want.z);
					if (quat_if.quat_w !== want.w) report_mismatch("quat_w", quat_if.quat_w, want.w);
					quats_checked++;
				end
			end
			quat_if.ready <= (hold_left == 0 && hold_request == 0) &&
				($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus phases
	initial begin
		cycles = 0;
		mismatches = 0;
		quats_checked = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, extremes, the -pi wrap code, quarter turns
		queue_angles(0, 0, 0);
		queue_angles(32767, 0, 0);
		queue_angles(0, 32767, 0);
		queue_angles(0, 0, 32767);
		queue_angles(-32768, 0, 0);
		queue_angles(0, -32768, 0);
		queue_angles(0, 0, -32768);
		queue_angles(-32768, -32768, -32768);
		queue_angles(32767, 32767, 32767);
		queue_angles(16384, 0, 0);
		queue_angles(0, 16384, 0);
		queue_angles(0, 0, 16384);
		queue_angles(-16384, -16384, -16384);
		queue_angles(1, -1, 1);
		queue_angles(-1, 1, -1);
		queue_angles(32767, -32768, 32767);
		queue_angles(16'h5555, 16'hAAAA, 16'h5555);
		queue_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		wait_drained();

		queue_random(400);
		wait_drained();

		send_idle_pct = 68;
		queue_random(400);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 68;
		queue_random(400);
		wait_drained();

		send_idle_pct = 35;
		recv_idle_pct = 35;
		queue_random(300);
		wait_drained();

		// back-pressure: the receiver stops long enough for the pipe to fill
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(150);
		@(negedge clk);
		hold_request = 400;
		@(posedge clk);
		@(negedge clk);
		hold_request = 0;
		wait_drained();

		repeat (200) @(posedge clk);
		$display("checked %0d quaternions from directed, random, idle and stall phases",
			quats_checked);
		$display("mismatch count %0d, predictions left %0d", mismatches, expected_quats.size());
		if (mismatches == 0 && expected_quats.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
